[hw/rtl/ncr_pkg.sv]
// Package with beat types, job type and character constants for the reference decoder.
`timescale 1ns / 1ps

package ncr_pkg;

	localparam int NcrQueueDepth = 2;

	localparam logic [7:0] ChHash = 8'h23;
	localparam logic [7:0] ChLowX = 8'h78;
	localparam logic [7:0] ChUpX  = 8'h58;
	localparam logic [7:0] ChZero = 8'h30;
	localparam logic [7:0] ChNine = 8'h39;
	localparam logic [7:0] ChUpA  = 8'h41;
	localparam logic [7:0] ChUpZ  = 8'h5A;
	localparam logic [7:0] ChLowA = 8'h61;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_beat_t;

	// One burst of one to four output bytes; last marks the final byte of the token.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      cnt_m1;
		logic            last;
	} job_t;

endpackage

[hw/rtl/ncr_front.sv]
// Front end: tracks the token, accumulates the code point and issues output jobs.
`timescale 1ns / 1ps

module ncr_front import ncr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_beat_t item,
	output logic     job_valid,
	output job_t     job,
	output logic     idle
);

	typedef enum logic [1:0] {
		ModeUndecided,
		ModeEcho,
		ModeDec,
		ModeHex
	} mode_t;

	mode_t       mode_q, mode_d;
	logic [1:0]  pos_q, pos_d;
	logic [31:0] acc_q, acc_d;
	logic [7:0]  held0_q, held1_q;
	logic [7:0]  b;
	logic [1:0]  pos_sat;
	logic [31:0] b_ext;
	logic [31:0] digit_dec, digit_hex;
	logic [31:0] acc_dec, acc_hex;
	job_t        utf_job;
	logic        utf_ok;
	job_t        flush_job;

	assign b         = item.in_byte;
	assign b_ext     = {24'b0, b};
	assign pos_sat   = (pos_q == 2'd3) ? 2'd2 : pos_q;
	assign digit_dec = b_ext - {24'b0, ChZero};
	assign acc_dec   = (acc_q << 3) + (acc_q << 1) + digit_dec;
	assign acc_hex   = (acc_q << 4) + digit_hex;
	assign idle      = (mode_q == ModeUndecided) && (pos_q == 2'd0);

	always_comb begin
		if (b >= ChZero && b <= ChNine) begin
			digit_hex = b_ext - {24'b0, ChZero};
		end else if (b >= ChUpA && b <= ChUpZ) begin
			digit_hex = b_ext - {24'b0, ChUpA} + 32'd10;
		end else begin
			digit_hex = b_ext - {24'b0, ChLowA} + 32'd10;
		end
	end

	// UTF-8 encoding of the accumulated value; surrogates and values past the
	// last code point produce no job.
	always_comb begin
		utf_job = '0;
		utf_job.last = 1'b1;
		utf_ok = 1'b1;
		if (acc_q < 32'h80) begin
			utf_job.bytes[0] = acc_q[7:0];
			utf_job.cnt_m1 = 2'd0;
		end else if (acc_q < 32'h800) begin
			utf_job.bytes[0] = {3'b110, acc_q[10:6]};
			utf_job.bytes[1] = {2'b10, acc_q[5:0]};
			utf_job.cnt_m1 = 2'd1;
		end else if (acc_q < 32'h10000) begin
			utf_ok = (acc_q[31:11] != 21'h1B);
			utf_job.bytes[0] = {4'b1110, acc_q[15:12]};
			utf_job.bytes[1] = {2'b10, acc_q[11:6]};
			utf_job.bytes[2] = {2'b10, acc_q[5:0]};
			utf_job.cnt_m1 = 2'd2;
		end else begin
			utf_ok = (acc_q <= 32'h10FFFF);
			utf_job.bytes[0] = {5'b11110, acc_q[20:18]};
			utf_job.bytes[1] = {2'b10, acc_q[17:12]};
			utf_job.bytes[2] = {2'b10, acc_q[11:6]};
			utf_job.bytes[3] = {2'b10, acc_q[5:0]};
			utf_job.cnt_m1 = 2'd3;
		end
	end

	always_comb begin
		flush_job = '0;
		flush_job.bytes[0] = (pos_sat == 2'd0) ? b : held0_q;
		flush_job.bytes[1] = (pos_sat == 2'd1) ? b : held1_q;
		flush_job.bytes[2] = b;
		flush_job.cnt_m1 = pos_sat;
		flush_job.last = 1'b1;
	end

	always_comb begin
		mode_d = mode_q;
		pos_d = pos_q;
		acc_d = acc_q;
		job = '0;
		job_valid = 1'b0;
		if (accept) begin
			unique case (mode_q)
				ModeEcho: begin
					job.bytes[0] = b;
					job.last = item.in_last;
					job_valid = 1'b1;
					if (item.in_last) begin
						mode_d = ModeUndecided;
						pos_d = 2'd0;
						acc_d = '0;
					end
				end
				ModeDec, ModeHex: begin
					if (item.in_last) begin
						job = utf_job;
						job_valid = utf_ok;
						mode_d = ModeUndecided;
						pos_d = 2'd0;
						acc_d = '0;
					end else if (mode_q == ModeDec) begin
						acc_d = acc_dec;
					end else begin
						acc_d = acc_hex;
					end
				end
				default: begin
					if (pos_q == 2'd1 && b != ChHash) begin
						job.bytes[0] = held0_q;
						job.bytes[1] = b;
						job.cnt_m1 = 2'd1;
						job.last = item.in_last;
						job_valid = 1'b1;
						if (item.in_last) begin
							pos_d = 2'd0;
							acc_d = '0;
						end else begin
							mode_d = ModeEcho;
							pos_d = 2'd2;
						end
					end else if (item.in_last) begin
						job = flush_job;
						job_valid = 1'b1;
						pos_d = 2'd0;
						acc_d = '0;
					end else if (pos_sat == 2'd2) begin
						if (b == ChLowX || b == ChUpX) begin
							mode_d = ModeHex;
							acc_d = '0;
						end else begin
							mode_d = ModeDec;
							acc_d = digit_dec;
						end
						pos_d = 2'd3;
					end else begin
						pos_d = pos_sat + 2'd1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ModeUndecided;
			pos_q <= 2'd0;
			acc_q <= '0;
		end else begin
			mode_q <= mode_d;
			pos_q <= pos_d;
			acc_q <= acc_d;
		end
	end

	// Only the first two bytes need holding; the third byte is the current beat.
	always_ff @(posedge clk) begin
		if (accept && mode_q == ModeUndecided) begin
			if (pos_sat == 2'd0) begin
				held0_q <= b;
			end
			if (pos_sat == 2'd1) begin
				held1_q <= b;
			end
		end
	end

endmodule

[hw/rtl/ncr_job_queue.sv]
// Small job queue between the front end and the byte emitter.
`timescale 1ns / 1ps

module ncr_job_queue import ncr_pkg::*; #(
	parameter int Depth = NcrQueueDepth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_job,
	output logic full,
	input  logic rd_en,
	output job_t rd_job,
	output logic empty
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	job_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign full   = (cnt_q == CntW'(Depth));
	assign empty  = (cnt_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

[hw/rtl/ncr_emitter.sv]
// Back end: holds one job and presents its bytes one beat at a time.
`timescale 1ns / 1ps

module ncr_emitter import ncr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  job_t      q_job,
	output logic      q_pop,
	output out_beat_t result,
	output logic      empty,
	input  logic      pop
);

	job_t       cur_q;
	logic       valid_q;
	logic [1:0] idx_q;
	logic       done;

	assign done  = valid_q && pop && (idx_q == cur_q.cnt_m1);
	assign q_pop = !q_empty && (!valid_q || done);
	assign empty = !valid_q;

	assign result.out_byte = cur_q.bytes[idx_q];
	assign result.out_last = (idx_q == cur_q.cnt_m1) && cur_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= 2'd0;
		end else begin
			if (q_pop) begin
				valid_q <= 1'b1;
				idx_q <= 2'd0;
			end else if (done) begin
				valid_q <= 1'b0;
				idx_q <= 2'd0;
			end else if (valid_q && pop) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_job;
		end
	end

endmodule

[hw/rtl/numeric_char_ref_to_utf8_core.sv]
// Top level of the numeric character reference to UTF-8 decoder.
`timescale 1ns / 1ps
//
//   Channel   Handshake     Beat fields
//   item      push / full   in_byte, in_last
//   result    pop / empty   out_byte, out_last
//
// One input beat is taken every cycle while the job queue has room.
// The emitter sends one result beat per cycle while pop is high, so a token end
// costs up to four result beats; the single byte port sets the sustained rate.
// All control state clears asynchronously on arst_n; empty is high after reset.
// A stalled result side fills the job queue and then raises full.

module numeric_char_ref_to_utf8_core import ncr_pkg::*; #(
	parameter int QueueDepth = NcrQueueDepth
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_beat_t  item,
	input  logic      pop,
	output logic      empty,
	output out_beat_t result
);

	logic accept;
	logic job_valid;
	job_t job;
	logic front_idle;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	job_t q_job;

	assign accept = push && !q_full;
	assign full   = q_full;
	assign q_push = accept && job_valid;

	ncr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.job_valid (job_valid),
		.job       (job),
		.idle      (front_idle)
	);

	ncr_job_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_job (job),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_job (q_job),
		.empty  (q_empty)
	);

	ncr_emitter u_emitter (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_job   (q_job),
		.q_pop   (q_pop),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

	// A token's final beat returns the front end to its start state.
	a_token_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.in_last |=> front_idle)
		else $error("front end not idle after token end");

	// The emitter only draws jobs that are present.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("job queue read while empty");

	// A held result that is not popped stays, even when the queue has a job ready.
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while stalled");

	// Every job written into the queue is kept.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job queue written while full");

endmodule

[sim/tb_numeric_char_ref_to_utf8_core.sv]
// Self-checking testbench for the numeric character reference to UTF-8 decoder core.
`timescale 1ns / 1ps

module tb_numeric_char_ref_to_utf8_core import ncr_pkg::*;;

	localparam int DirRows     = 24;
	localparam int RandomItems = 256;
	localparam int StallLimit  = 2000;
	localparam int DrainCycles = 16;

	typedef enum logic [1:0] {ModeOpen, ModeEcho, ModeDec, ModeHex} tok_mode_e;

	typedef struct packed {
		logic [7:0]       in_byte;
		logic             in_last;
		logic             typed;
		logic [2:0]       n;
		out_beat_t [0:3]  beats;
	} dir_row_t;

	// Tokens: "&#;", "&#x;", "&#x10FFFF;", raw 00 FF, raw FF, and "&#<00>;" which wraps to a
	// value too large to encode.
	localparam dir_row_t DirTable [DirRows] = '{
		'{8'h26, 1'b0, 1'b0, 3'd0, 36'h0},
		'{8'h23, 1'b0, 1'b0, 3'd0, 36'h0},
		'{8'h3B, 1'b1, 1'b1, 3'd3, {9'h04C, 9'h046, 9'h077, 9'h000}},
		'{8'h26, 1'b0, 1'b0, 3'd0, 36'h0},
		'{8'h23, 1'b0, 1'b0, 3'd0, 36'h0},
		'{8'h78, 1'b0, 1'b0, 3'd0, 36'h0},
		'{8'h3B, 1'b1, 1'b1, 3'd1, {9'h001, 9'h000, 9'h000, 9'h000}},
		'{8'h26, 1'b0, 1'b0, 3'd0, 36'h0},
		'{8'h23, 1'b0, 1'b0, 3'd0, 36'h0},
		'{8'h78, 1'b0, 1'b0, 3'd0, 36'h0},
		'{8'h31, 1'b0, 1'b0, 3'd0, 36'h0},
		'{8'h30, 1'b0, 1'b0, 3'd0, 36'h0},
		'{8'h46, 1'b0, 1'b0, 3'd0, 36'h0},
		'{8'h46, 1'b0, 1'b0, 3'd0, 36'h0},
		'{8'h46, 1'b0, 1'b0, 3'd0, 36'h0},
		'{8'h46, 1'b0, 1'b0, 3'd0, 36'h0},
		'{8'h3B, 1'b1, 1'b1, 3'd4, {9'h1E8, 9'h11E, 9'h17E, 9'h17F}},
		'{8'h00, 1'b0, 1'b0, 3'd0, 36'h0},
		'{8'hFF, 1'b1, 1'b1, 3'd2, {9'h000, 9'h1FF, 9'h000, 9'h000}},
		'{8'hFF, 1'b1, 1'b1, 3'd1, {9'h1FF, 9'h000, 9'h000, 9'h000}},
		'{8'h26, 1'b0, 1'b0, 3'd0, 36'h0},
		'{8'h23, 1'b0, 1'b0, 3'd0, 36'h0},
		'{8'h00, 1'b0, 1'b0, 3'd0, 36'h0},
		'{8'h3B, 1'b1, 1'b1, 3'd0, 36'h0}
	};

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      push   = 1'b0;
	logic      pop    = 1'b0;
	in_beat_t  item   = '0;
	logic      full;
	logic      empty;
	out_beat_t result;

	bit        steady = 1'b0;
	int        errors = 0;
	int        bytes_in = 0;
	int        bytes_out = 0;
	int        tokens = 0;
	int        numeric_tokens = 0;
	int        dropped_tokens = 0;
	int        stall_cycles = 0;

	tok_mode_e   mode = ModeOpen;
	logic [1:0]  tok_pos = '0;
	logic [7:0]  held [3];
	logic [31:0] code = '0;

	out_beat_t utf8_pending [$];

	numeric_char_ref_to_utf8_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		pop <= steady || ($urandom_range(99) >= 16);
	end

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && pop && !empty) begin
			bytes_out++;
			if (utf8_pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none, actual byte %h last %b",
					$time, result.out_byte, result.out_last);
			end else begin
				want = utf8_pending.pop_front();
				if (result.out_byte !== want.out_byte) begin
					errors++;
					$display("%0t: out_byte mismatch, expected %h, actual %h",
						$time, want.out_byte, result.out_byte);
				end
				if (result.out_last !== want.out_last) begin
					errors++;
					$display("%0t: out_last mismatch, expected %b, actual %b",
						$time, want.out_last, result.out_last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles == StallLimit) begin
				$display("%0t: no beat accepted for %0d cycles", $time, StallLimit);
				$display("numeric_char_ref_to_utf8_core test failed");
				$finish;
			end
		end
	end

	// Sends one beat, then updates the decoder model and queues the bytes it predicts.
	// A typed row replaces the predicted bytes with the ones written in the table.
	task automatic send_beat(input in_beat_t b, input bit typed, input int n,
			input out_beat_t [0:3] beats);
		out_beat_t   burst [$];
		logic [7:0]  c;
		logic [31:0] v;
		logic [31:0] dig;
		logic [1:0]  p;
		bit          done;
		while (!steady && $urandom_range(99) < 16) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		bytes_in++;

		c = b.in_byte;
		done = 1'b0;
		case (mode)
			ModeEcho: begin
				burst.push_back(out_beat_t'({c, b.in_last}));
				done = b.in_last;
			end
			ModeDec, ModeHex: begin
				if (b.in_last) begin
					v = code;
					numeric_tokens++;
					if (v < 32'h80) begin
						burst.push_back(out_beat_t'({v[7:0], 1'b1}));
					end else if (v < 32'h800) begin
						burst.push_back(out_beat_t'({3'b110, v[10:6], 1'b0}));
						burst.push_back(out_beat_t'({2'b10, v[5:0], 1'b1}));
					end else if (v < 32'h10000) begin
						if (v < 32'hD800 || v > 32'hDFFF) begin
							burst.push_back(out_beat_t'({4'b1110, v[15:12], 1'b0}));
							burst.push_back(out_beat_t'({2'b10, v[11:6], 1'b0}));
							burst.push_back(out_beat_t'({2'b10, v[5:0], 1'b1}));
						end
					end else if (v <= 32'h10FFFF) begin
						burst.push_back(out_beat_t'({5'b11110, v[20:18], 1'b0}));
						burst.push_back(out_beat_t'({2'b10, v[17:12], 1'b0}));
						burst.push_back(out_beat_t'({2'b10, v[11:6], 1'b0}));
						burst.push_back(out_beat_t'({2'b10, v[5:0], 1'b1}));
					end
					if (burst.size() == 0)
						dropped_tokens++;
					done = 1'b1;
				end else if (mode == ModeDec) begin
					code = code * 32'd10 + ({24'h0, c} - {24'h0, ChZero});
				end else begin
					if (c >= ChZero && c <= ChNine)
						dig = {24'h0, c} - {24'h0, ChZero};
					else if (c >= ChUpA && c <= ChUpZ)
						dig = {24'h0, c} - {24'h0, ChUpA} + 32'd10;
					else
						dig = {24'h0, c} - {24'h0, ChLowA} + 32'd10;
					code = code * 32'd16 + dig;
				end
			end
			default: begin
				if (tok_pos == 2'd1 && c != ChHash) begin
					burst.push_back(out_beat_t'({held[0], 1'b0}));
					burst.push_back(out_beat_t'({c, b.in_last}));
					if (b.in_last) begin
						done = 1'b1;
					end else begin
						mode = ModeEcho;
						tok_pos = 2'd2;
					end
				end else begin
					p = (tok_pos > 2'd2) ? 2'd2 : tok_pos;
					held[p] = c;
					if (b.in_last) begin
						for (int i = 0; i <= int'(p); i++)
							burst.push_back(out_beat_t'({held[i], i == int'(p)}));
						done = 1'b1;
					end else if (p == 2'd2) begin
						if (c == ChLowX || c == ChUpX) begin
							mode = ModeHex;
							code = '0;
						end else begin
							mode = ModeDec;
							code = {24'h0, c} - {24'h0, ChZero};
						end
						tok_pos = 2'd3;
					end else begin
						tok_pos = p + 2'd1;
					end
				end
			end
		endcase
		if (done) begin
			tokens++;
			tok_pos = '0;
			mode = ModeOpen;
			code = '0;
		end

		if (typed) begin
			for (int i = 0; i < n; i++)
				utf8_pending.push_back(beats[i]);
		end else begin
			foreach (burst[i])
				utf8_pending.push_back(burst[i]);
		end
	endtask

	initial begin
		in_beat_t    ib;
		logic [7:0]  tok [$];
		logic [7:0]  digs [$];
		int unsigned kind;
		int unsigned val;
		int unsigned d;
		int unsigned len;
		bit          as_hex;
		bit          paused;

		paused = 1'b0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DirRows; r++) begin
			ib.in_byte = DirTable[r].in_byte;
			ib.in_last = DirTable[r].in_last;
			send_beat(ib, DirTable[r].typed, int'(DirTable[r].n), DirTable[r].beats);
		end

		while (bytes_in < DirRows + RandomItems) begin
			steady = (bytes_in >= DirRows + 120 && bytes_in < DirRows + 180);
			if (!paused && bytes_in >= DirRows + 200) begin
				paused = 1'b1;
				push <= 1'b0;
				@(posedge clk);
				while (utf8_pending.size() != 0)
					@(posedge clk);
			end

			tok.delete();
			kind = $urandom_range(99);
			if (kind < 75) begin
				tok.push_back(8'h26);
				tok.push_back(ChHash);
				as_hex = $urandom_range(1);
				if (as_hex)
					tok.push_back($urandom_range(1) ? ChLowX : ChUpX);
				if (kind < 60) begin
					case ($urandom_range(5))
						0: val = $urandom_range(127);
						1: val = $urandom_range(32'h7FF, 32'h80);
						2: val = $urandom_range(32'hFFFF, 32'h800);
						3: val = $urandom_range(32'h10FFFF, 32'h10000);
						4: val = $urandom_range(32'hDFFF, 32'hD800);
						default: val = $urandom_range(32'hFFFFFFFF, 32'h110000);
					endcase
					digs.delete();
					do begin
						d = as_hex ? val % 16 : val % 10;
						if (d < 10)
							digs.push_front(ChZero + 8'(d));
						else
							digs.push_front(($urandom_range(1) ? ChUpA : ChLowA) + 8'(d - 10));
						val = as_hex ? val / 16 : val / 10;
					end while (val != 0);
					foreach (digs[i])
						tok.push_back(digs[i]);
				end else begin
					len = $urandom_range(6, 1);
					repeat (len)
						tok.push_back(8'($urandom_range(255)));
				end
				tok.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'h3B);
			end else if (kind < 90) begin
				len = $urandom_range(6, 1);
				repeat (len)
					tok.push_back(8'($urandom_range(255)));
				if ($urandom_range(1))
					tok[0] = 8'h26;
			end else begin
				tok.push_back(8'h26);
				tok.push_back(ChHash);
				if ($urandom_range(1))
					tok.push_back(8'($urandom_range(255)));
			end

			foreach (tok[i]) begin
				ib.in_byte = tok[i];
				ib.in_last = (i == tok.size() - 1);
				send_beat(ib, 1'b0, 0, '0);
			end
		end
		steady = 1'b0;
		push <= 1'b0;

		while (utf8_pending.size() != 0)
			@(posedge clk);
		repeat (DrainCycles)
			@(posedge clk);

		$display("Sent %0d bytes in %0d tokens and checked %0d bytes out.",
			bytes_in, tokens, bytes_out);
		$display("Numeric references: %0d, of which %0d could not be encoded.",
			numeric_tokens, dropped_tokens);
		if (errors == 0 && utf8_pending.size() == 0) begin
			$display("numeric_char_ref_to_utf8_core test passed");
		end else begin
			$display("numeric_char_ref_to_utf8_core test failed");
		end
		$finish;
	end

endmodule

[numeric_char_ref_to_utf8_core.f]
hw/rtl/ncr_pkg.sv
hw/rtl/ncr_front.sv
hw/rtl/ncr_job_queue.sv
hw/rtl/ncr_emitter.sv
hw/rtl/numeric_char_ref_to_utf8_core.sv
sim/tb_numeric_char_ref_to_utf8_core.sv
